### rtl/core/lrtf_pkg.sv
// Shared types and constants for the longest-remaining-time-first scheduler.
// Used by lrtf_process_scheduler; no dependencies.
package lrtf_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int DATA_W = 16;
  localparam int TIME_W = 32;
  localparam int PROC_W = 5;

  localparam int IN_TDATA_W  = 2 * DATA_W;
  localparam int OUT_BITS    = 4 * TIME_W + PROC_W + 2;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT
  } lrtf_state_e;

  typedef struct packed {
    logic [DATA_W-1:0] arrival;
    logic [DATA_W-1:0] burst;
    logic [DATA_W-1:0] remaining;
  } lrtf_entry_t;

  localparam int ENTRY_W = $bits(lrtf_entry_t);

endpackage

### rtl/core/lrtf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lrtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/lrtf_process_scheduler.sv
// Top level of the longest-remaining-time-first process scheduler.
// Depends on lrtf_pkg and lrtf_ram.

// A load transfer (tuser 0) yields no result. A tick transfer (tuser 1) scans the
// process table, held in one RAM with one read port, one slot per cycle. The scan
// reads every loaded slot, an update state writes any picked entry back, and an emit
// state loads the result; the block then returns to idle to take the next transfer.
// The result is written to an output register and the next transfer is taken while
// it waits; a further tick holds in its emit state until that register is free. A
// tick whose process finishes reports completion, turnaround and waiting time; all
// other result fields of that kind are zero.
module lrtf_process_scheduler (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // arrival_time [15:0], burst_time [31:16]
  input  logic [lrtf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // operation [0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // slot_start [31:0], running_process [36:32], finished [37],
  // completion_time [69:38], turnaround_time [101:70], waiting_time [133:102],
  // all_done [134], zero [135]
  output logic [lrtf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  import lrtf_pkg::*;

  lrtf_state_e state_q, state_d;

  logic [CNT_W-1:0]  loaded_q, pending_q, idx_q;
  logic [SLOTS-1:0]  done_q;
  logic [TIME_W-1:0] time_q, start_q, end_w;

  logic              chk_vld_q;
  logic [SLOT_W-1:0] chk_slot_q;
  logic              found_q;
  logic [SLOT_W-1:0] best_slot_q;
  lrtf_entry_t       best_q;

  logic [PROC_W-1:0] res_proc_q;
  logic              res_fin_q;
  logic [TIME_W-1:0] res_comp_q, res_tat_q;
  logic [DATA_W-1:0] res_bur_q;

  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

  logic              in_xfer, do_load, is_tick, emit_ld;
  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  lrtf_entry_t       ram_wdata, rd_entry;
  logic [DATA_W-1:0] in_arr, in_bur, new_rem;
  logic              elig, better, fin_w;
  logic [TIME_W-1:0] wt_w;

  assign in_arr  = s_axis_tdata[DATA_W-1:0];
  assign in_bur  = s_axis_tdata[2*DATA_W-1:DATA_W];
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign is_tick = in_xfer && (s_axis_tuser == OP_TICK);
  assign do_load = in_xfer && (s_axis_tuser == OP_LOAD) &&
                   (loaded_q < CNT_W'(SLOTS)) && (in_bur != '0);

  assign end_w   = (start_q == TIME_MAX) ? start_q : start_q + TIME_W'(1);
  assign new_rem = (best_q.remaining == '0) ? '0 : best_q.remaining - DATA_W'(1);
  assign fin_w   = found_q && (new_rem == '0);

  assign elig   = chk_vld_q && !done_q[chk_slot_q] &&
                  (TIME_W'(rd_entry.arrival) <= start_q);
  assign better = !found_q || (rd_entry.remaining > best_q.remaining) ||
                  ((rd_entry.remaining == best_q.remaining) &&
                   (rd_entry.arrival < best_q.arrival));

  assign wt_w = (res_fin_q && (res_tat_q >= TIME_W'(res_bur_q))) ?
                res_tat_q - TIME_W'(res_bur_q) : '0;

  lrtf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rd_entry)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (is_tick) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_q == loaded_q) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: state_d = ST_EMIT;
      ST_EMIT: begin
        if (emit_ld) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = loaded_q[SLOT_W-1:0];
    ram_wdata     = '{arrival: in_arr, burst: in_bur, remaining: in_bur};
    ram_re        = 1'b0;
    ram_raddr     = idx_q[SLOT_W-1:0];
    emit_ld       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ram_we        = do_load;
      end
      ST_SCAN: begin
        ram_re = (idx_q < loaded_q);
      end
      ST_UPDATE: begin
        ram_we    = found_q;
        ram_waddr = best_slot_q;
        ram_wdata = '{arrival: best_q.arrival, burst: best_q.burst, remaining: new_rem};
      end
      ST_EMIT: begin
        emit_ld = !m_valid_q || m_axis_tready;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    m_data_d = '0;
    m_data_d[TIME_W-1:0]                 = start_q;
    m_data_d[TIME_W +: PROC_W]           = res_proc_q;
    m_data_d[TIME_W+PROC_W]              = res_fin_q;
    m_data_d[TIME_W+PROC_W+1 +: TIME_W]  = res_comp_q;
    m_data_d[2*TIME_W+PROC_W+1 +: TIME_W] = res_tat_q;
    m_data_d[3*TIME_W+PROC_W+1 +: TIME_W] = wt_w;
    m_data_d[4*TIME_W+PROC_W+1]          = (pending_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      loaded_q  <= '0;
      pending_q <= '0;
      done_q    <= '0;
      time_q    <= '0;
      idx_q     <= '0;
      chk_vld_q <= 1'b0;
      found_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_load && (state_q == ST_IDLE)) begin
        loaded_q  <= loaded_q + CNT_W'(1);
        pending_q <= pending_q + CNT_W'(1);
        done_q[loaded_q[SLOT_W-1:0]] <= 1'b0;
      end
      if (is_tick) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end
      chk_vld_q <= ram_re;
      if (ram_re) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (state_q == ST_SCAN && elig && better) begin
        found_q <= 1'b1;
      end
      if (state_q == ST_UPDATE) begin
        time_q <= end_w;
        if (fin_w) begin
          done_q[best_slot_q] <= 1'b1;
          if (pending_q != '0) begin
            pending_q <= pending_q - CNT_W'(1);
          end
        end
      end
      if (emit_ld) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_tick) begin
      start_q <= time_q;
    end
    if (ram_re) begin
      chk_slot_q <= idx_q[SLOT_W-1:0];
    end
    if (state_q == ST_SCAN && elig && better) begin
      best_slot_q <= chk_slot_q;
      best_q      <= rd_entry;
    end
    if (state_q == ST_UPDATE) begin
      res_proc_q <= found_q ? PROC_W'({1'b0, best_slot_q} + (SLOT_W + 1)'(1)) : '0;
      res_fin_q  <= fin_w;
      res_comp_q <= fin_w ? end_w : '0;
      res_tat_q  <= fin_w ? end_w - TIME_W'(best_q.arrival) : '0;
      res_bur_q  <= best_q.burst;
    end
    if (emit_ld) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) pending_q <= loaded_q)
    else $error("pending count exceeds loaded count");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we && ram_re))
    else $error("table written and read in the same cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q <= loaded_q))
    else $error("scan index ran past the loaded slots");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && found_q) |-> (best_q.remaining != '0))
    else $error("picked process has no remaining time");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready) |=> $stable(m_data_q))
    else $error("pending result changed before transfer");

endmodule
